FILE: sv/bsmw_pkg.sv
// Package for the byte-addressed operand stack: store geometry, operation
// and status codes shared by the core, its storage banks and the checker.
// No dependencies.
package bsmw_pkg;

  // Store geometry: bytes are spread over eight byte-wide banks.
  localparam int STORE_BYTES = 4096;
  localparam int BANKS       = 8;
  localparam int BANK_W      = $clog2(BANKS);
  localparam int ROWS        = STORE_BYTES / BANKS;
  localparam int ROW_W       = $clog2(ROWS);

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 2;
  localparam int OFF_W   = 12;
  localparam int VAL_W   = 64;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 13;
  localparam int NB_W    = 4;   // byte count 1..8

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // Operation codes.
  localparam logic [KIND_W-1:0] K_READ  = 2'd0;
  localparam logic [KIND_W-1:0] K_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] K_PUSH  = 2'd2;
  localparam logic [KIND_W-1:0] K_POP   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [LEVEL_W-1:0] CAP_RESET = LEVEL_W'(STORE_BYTES);

  // Bank-side access request.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ROW_W-1:0] row;
    logic [7:0]       wdata;
  } bank_req_t;

endpackage

FILE: sv/bsmw_bank.sv
// One byte lane of the stack store: ROWS x 8 synchronous memory, one
// access per cycle, read data registered. Uses bsmw_pkg.
module bsmw_bank (
  input  logic                clk,
  input  bsmw_pkg::bank_req_t req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [bsmw_pkg::ROWS];
  logic [7:0] rdata_r;

  // Write or registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.row] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.row];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/byte_stack_mixed_width_access_core.sv
// Byte-addressed operand stack with fill level, little-endian 1/2/4/8 byte
// values. Top level; uses bsmw_pkg and bsmw_bank.

// The stack accepts one word per cycle while the output is not stalled and
// returns one result word per item, through the registered bank read and
// then the output register. The 4096-byte store is interleaved over eight
// byte-wide banks, so any unaligned access of up to eight bytes touches
// each bank at most once and all its bytes are accessed together. An item
// is either a read (read, pop) or a write (write, push) of the banks, never
// both, so no read-modify-write interlock exists. A failed operation (out
// of range, overflow, underflow) leaves the store and level unchanged and
// returns zero data. The user must write the capacity register through the
// cfg_ channel only while no item is in flight; the block does not enforce
// it. Values above 4096 act as 4096. Store contents are undefined after
// reset; only bytes below the fill level are ever returned.
module byte_stack_mixed_width_access_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: kind[1:0], size_code[3:2], byte_offset[15:4], write_value[79:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  // out_tdata: read_data[63:0], status[65:64], fill_level[78:66], zero[79]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  // capacity_limit write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  localparam int NB = bsmw_pkg::BANKS;
  localparam int BW = bsmw_pkg::BANK_W;
  localparam int LW = bsmw_pkg::LEVEL_W;

  // Input fields
  logic [bsmw_pkg::KIND_W-1:0] in_kind;
  logic [bsmw_pkg::SIZE_W-1:0] in_size;
  logic [bsmw_pkg::OFF_W-1:0]  in_off;
  logic [bsmw_pkg::VAL_W-1:0]  in_val;

  assign in_kind = in_tdata[1:0];
  assign in_size = in_tdata[3:2];
  assign in_off  = in_tdata[15:4];
  assign in_val  = in_tdata[79:16];

  // Control state
  logic [LW-1:0] cap_r;
  logic [LW-1:0] level_r, level_nxt;
  logic          s1_v_r;
  logic          out_v_r;
  logic          acc;
  logic          out_free;

  // Stage one meta data (payload)
  logic [bsmw_pkg::STAT_W-1:0] s1_status_r, status_nxt;
  logic [LW-1:0]               s1_level_r;
  logic [BW-1:0]               s1_lo_r;
  logic [bsmw_pkg::NB_W-1:0]   s1_n_r;
  logic                        s1_rd_r;

  // Output register (payload)
  logic [bsmw_pkg::VAL_W-1:0]  out_data_r, out_data_nxt;
  logic [bsmw_pkg::STAT_W-1:0] out_status_r;
  logic [LW-1:0]               out_level_r;

  // Access decode
  logic [bsmw_pkg::NB_W-1:0]  nbytes;
  logic [LW-1:0]              cap_eff;
  logic [LW-1:0]              off_end;
  logic [LW-1:0]              pop_level;
  logic [bsmw_pkg::OFF_W-1:0] addr;
  logic                       do_rd, do_wr;

  assign out_free  = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || out_free;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign nbytes    = bsmw_pkg::NB_W'(1) << in_size;
  assign cap_eff   = (cap_r > bsmw_pkg::CAP_RESET) ? bsmw_pkg::CAP_RESET : cap_r;
  assign off_end   = {1'b0, in_off} + LW'(nbytes);
  assign pop_level = level_r - LW'(nbytes);

  // Operation checks and new level
  always_comb begin
    status_nxt = bsmw_pkg::ST_OK;
    level_nxt  = level_r;
    do_rd      = 1'b0;
    do_wr      = 1'b0;
    addr       = in_off;
    unique case (in_kind)
      bsmw_pkg::K_READ: begin
        if (off_end > level_r) status_nxt = bsmw_pkg::ST_RANGE;
        else                   do_rd      = 1'b1;
      end
      bsmw_pkg::K_WRITE: begin
        if (off_end > level_r) status_nxt = bsmw_pkg::ST_RANGE;
        else                   do_wr      = 1'b1;
      end
      bsmw_pkg::K_PUSH: begin
        addr = level_r[bsmw_pkg::OFF_W-1:0];
        if (level_r > cap_eff || LW'(nbytes) > cap_eff - level_r) begin
          status_nxt = bsmw_pkg::ST_OVERFLOW;
        end else begin
          do_wr     = 1'b1;
          level_nxt = level_r + LW'(nbytes);
        end
      end
      bsmw_pkg::K_POP: begin
        addr = pop_level[bsmw_pkg::OFF_W-1:0];
        if (LW'(nbytes) > level_r) begin
          status_nxt = bsmw_pkg::ST_UNDERFLOW;
        end else begin
          do_rd     = 1'b1;
          level_nxt = pop_level;
        end
      end
      default: status_nxt = bsmw_pkg::ST_OK;
    endcase
  end

  // Bank lanes: byte i of the value lives in bank (addr + i) mod 8
  logic [BW-1:0]               lo;
  logic [bsmw_pkg::ROW_W-1:0]  base_row;
  logic [7:0]                  bank_q [NB];

  assign lo       = addr[BW-1:0];
  assign base_row = addr[bsmw_pkg::OFF_W-1:BW];

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [BW-1:0]       idx;
    bsmw_pkg::bank_req_t req;

    assign idx       = BW'(b) - lo;
    assign req.row   = base_row + ((BW'(b) < lo) ? bsmw_pkg::ROW_W'(1)
                                                 : bsmw_pkg::ROW_W'(0));
    assign req.we    = acc && do_wr && ({1'b0, idx} < nbytes);
    assign req.re    = acc && do_rd;
    assign req.wdata = in_val[8*idx +: 8];

    bsmw_bank u_bank (
      .clk   (clk),
      .req   (req),
      .rdata (bank_q[b])
    );
  end

  // Rotate bank read data back into value order and mask to the width
  always_comb begin
    logic [BW-1:0] sel;
    out_data_nxt = '0;
    for (int i = 0; i < NB; i++) begin
      sel = s1_lo_r + BW'(i);
      if (s1_rd_r && (bsmw_pkg::NB_W'(i) < s1_n_r)) begin
        out_data_nxt[8*i +: 8] = bank_q[sel];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= bsmw_pkg::CAP_RESET;
      level_r <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (acc) level_r <= level_nxt;
      if (in_tready) s1_v_r <= acc;
      if (out_free) out_v_r <= s1_v_r;
    end
  end

  // Stage one and output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status_r <= status_nxt;
      s1_level_r  <= level_nxt;
      s1_lo_r     <= lo;
      s1_n_r      <= nbytes;
      s1_rd_r     <= do_rd;
    end
    if (out_free && s1_v_r) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= s1_status_r;
      out_level_r  <= s1_level_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_level_r, out_status_r, out_data_r};

endmodule

FILE: sv/bsmw_checker.sv
// Port-level checks for the operand stack core, bound to the top level.
// Uses bsmw_pkg for codes and widths.
module bsmw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  logic [1:0]  o_status;
  logic [63:0] o_data;
  logic [12:0] o_level;

  assign o_data   = out_tdata[63:0];
  assign o_status = out_tdata[65:64];
  assign o_level  = out_tdata[78:66];

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Failed operations return zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status != bsmw_pkg::ST_OK |-> o_data == '0)
    else $error("nonzero data on error result");

  // Fill level never exceeds the store
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_level <= bsmw_pkg::CAP_RESET)
    else $error("fill level above store size");

  // Underflow only when fewer than eight bytes are held
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status == bsmw_pkg::ST_UNDERFLOW |-> o_level < 13'd8)
    else $error("underflow reported with enough bytes");

  // No result word directly after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind byte_stack_mixed_width_access_core bsmw_checker u_bsmw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
